// ----- sv/eev_pkg.sv -----
// Shared types and constants for exception entry vectoring.
// Holds exception kinds, cause codes, vector addresses and the item structs.
// No dependencies.
package eev_pkg;

   localparam logic [4:0] ACT_INT    = 5'd0;
   localparam logic [4:0] ACT_TLBMOD = 5'd1;
   localparam logic [4:0] ACT_REFILL = 5'd2;
   localparam logic [4:0] ACT_TLBINV = 5'd3;
   localparam logic [4:0] ACT_ADEL   = 5'd4;
   localparam logic [4:0] ACT_BUS    = 5'd5;
   localparam logic [4:0] ACT_SYS    = 5'd6;
   localparam logic [4:0] ACT_BP     = 5'd7;
   localparam logic [4:0] ACT_RI     = 5'd8;
   localparam logic [4:0] ACT_CPU    = 5'd9;
   localparam logic [4:0] ACT_OV     = 5'd10;
   localparam logic [4:0] ACT_TRAP   = 5'd11;
   localparam logic [4:0] ACT_FPE    = 5'd12;
   localparam logic [4:0] ACT_RESET  = 5'd13;
   localparam logic [4:0] ACT_NMI    = 5'd14;
   localparam logic [4:0] ACT_PERF   = 5'd15;
   localparam logic [4:0] ACT_DEBUG  = 5'd16;
   localparam logic [4:0] ACT_SIO    = 5'd17;

   localparam logic [1:0] AK_FETCH = 2'd0;
   localparam logic [1:0] AK_WRITE = 2'd2;

   localparam logic [4:0] EXC_INT   = 5'd0;
   localparam logic [4:0] EXC_MOD   = 5'd1;
   localparam logic [4:0] EXC_TLBL  = 5'd2;
   localparam logic [4:0] EXC_TLBS  = 5'd3;
   localparam logic [4:0] EXC_ADEL  = 5'd4;
   localparam logic [4:0] EXC_ADES  = 5'd5;
   localparam logic [4:0] EXC_IBE   = 5'd6;
   localparam logic [4:0] EXC_DBE   = 5'd7;
   localparam logic [4:0] EXC_SYS   = 5'd8;
   localparam logic [4:0] EXC_BP    = 5'd9;
   localparam logic [4:0] EXC_RI    = 5'd10;
   localparam logic [4:0] EXC_CPU   = 5'd11;
   localparam logic [4:0] EXC_OV    = 5'd12;
   localparam logic [4:0] EXC_TRAP  = 5'd13;
   localparam logic [4:0] EXC_FPE   = 5'd15;

   localparam logic [1:0] EXC2_RESET = 2'd0;
   localparam logic [1:0] EXC2_NMI   = 2'd1;
   localparam logic [1:0] EXC2_PERF  = 2'd2;
   localparam logic [1:0] EXC2_DEBUG = 2'd3;

   localparam logic [1:0] AW_NONE    = 2'd0;
   localparam logic [1:0] AW_VADDR   = 2'd1;
   localparam logic [1:0] AW_CONTEXT = 2'd2;
   localparam logic [1:0] AW_PADDR   = 2'd3;

   localparam logic [1:0] SE_NONE    = 2'd0;
   localparam logic [1:0] SE_SET_BEV = 2'd1;
   localparam logic [1:0] SE_RESET   = 2'd2;

   localparam logic [31:0] VEC_COMMON_BOOT  = 32'hBFC0_0380;
   localparam logic [31:0] VEC_COMMON_RAM   = 32'h8000_0180;
   localparam logic [31:0] VEC_INT_BOOT     = 32'hBFC0_0400;
   localparam logic [31:0] VEC_INT_RAM      = 32'h8000_0200;
   localparam logic [31:0] VEC_REFILL_BOOT  = 32'hBFC0_0200;
   localparam logic [31:0] VEC_REFILL_RAM   = 32'h8000_0000;
   localparam logic [31:0] REFILL_NEST_OFS  = 32'h0000_0180;
   localparam logic [31:0] VEC_DEBUG_BOOT   = 32'hBFC0_0300;
   localparam logic [31:0] VEC_DEBUG_RAM    = 32'h8000_0100;
   localparam logic [31:0] VEC_PERF_BOOT    = 32'hBFC0_0280;
   localparam logic [31:0] VEC_PERF_RAM     = 32'h8000_0080;
   localparam logic [31:0] VEC_RESET        = 32'hBFC0_0000;

   typedef struct packed {
      logic [4:0]  action;
      logic [31:0] current_pc;
      logic        in_delay_slot;
      logic [1:0]  access_kind;
      logic [31:0] fault_address;
      logic [1:0]  cop_index;
      logic        exl_now;
      logic        bev_now;
      logic        bem_now;
      logic        dev_now;
   } req_type;

   typedef struct packed {
      logic [31:0] new_pc;
      logic        level;
      logic        save_return;
      logic [31:0] return_pc;
      logic        delay_flag;
      logic [4:0]  cause_code;
      logic [1:0]  exc2_code;
      logic [1:0]  cop_number;
      logic [1:0]  address_writes;
      logic [18:0] context_vpn2;
      logic [1:0]  status_effect;
      logic        set_siop;
   } rsp_type;

endpackage

// ----- sv/eev_req_if.sv -----
// Request channel: valid/ready handshake carrying one exception entry item.
// Depends on eev_pkg.
interface eev_req_if;
   logic             valid;
   logic             ready;
   eev_pkg::req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- sv/eev_rsp_if.sv -----
// Response channel: valid/ready handshake carrying one vector and update set.
// Depends on eev_pkg.
interface eev_rsp_if;
   logic             valid;
   logic             ready;
   eev_pkg::rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- sv/eev_decode.sv -----
// Combinational exception entry decode: vector, level, cause and updates.
// Depends on eev_pkg.
module eev_decode (
   input  eev_pkg::req_type req,
   output eev_pkg::rsp_type rsp
);
   import eev_pkg::*;

   logic [31:0] ret_addr;
   logic        is_write;
   logic [31:0] refill_base;

   assign ret_addr    = req.current_pc - (req.in_delay_slot ? 32'd8 : 32'd4);
   assign is_write    = (req.access_kind == AK_WRITE);
   assign refill_base = req.bev_now ? VEC_REFILL_BOOT : VEC_REFILL_RAM;

   always_comb begin
      rsp = '0;
      if (req.action <= ACT_FPE) begin
         rsp.save_return = ~req.exl_now;
         rsp.new_pc      = req.bev_now ? VEC_COMMON_BOOT : VEC_COMMON_RAM;
         unique case (req.action)
            ACT_INT: begin
               rsp.new_pc   = req.bev_now ? VEC_INT_BOOT : VEC_INT_RAM;
               rsp.cause_code = EXC_INT;
            end
            ACT_TLBMOD: begin
               rsp.cause_code     = EXC_MOD;
               rsp.address_writes = AW_CONTEXT;
            end
            ACT_REFILL: begin
               rsp.new_pc         = req.exl_now ? (refill_base | REFILL_NEST_OFS)
                                                : refill_base;
               rsp.cause_code     = is_write ? EXC_TLBS : EXC_TLBL;
               rsp.address_writes = AW_CONTEXT;
            end
            ACT_TLBINV: begin
               rsp.cause_code     = is_write ? EXC_TLBS : EXC_TLBL;
               rsp.address_writes = AW_CONTEXT;
            end
            ACT_ADEL: begin
               rsp.cause_code     = is_write ? EXC_ADES : EXC_ADEL;
               rsp.address_writes = AW_VADDR;
            end
            ACT_BUS: begin
               rsp.cause_code     = (req.access_kind == AK_FETCH) ? EXC_IBE : EXC_DBE;
               rsp.address_writes = req.bem_now ? AW_NONE : AW_PADDR;
            end
            ACT_SYS:  rsp.cause_code = EXC_SYS;
            ACT_BP:   rsp.cause_code = EXC_BP;
            ACT_RI:   rsp.cause_code = EXC_RI;
            ACT_CPU: begin
               rsp.cause_code = EXC_CPU;
               rsp.cop_number = req.cop_index;
            end
            ACT_OV:   rsp.cause_code = EXC_OV;
            ACT_TRAP: rsp.cause_code = EXC_TRAP;
            default:  rsp.cause_code = EXC_FPE;
         endcase
         if (~req.exl_now) begin
            rsp.return_pc  = ret_addr;
            rsp.delay_flag = req.in_delay_slot;
         end
         if (rsp.address_writes == AW_CONTEXT) begin
            rsp.context_vpn2 = req.fault_address[31:13];
         end
      end else if (req.action <= ACT_SIO) begin
         rsp.level       = 1'b1;
         rsp.save_return = 1'b1;
         rsp.return_pc   = ret_addr;
         rsp.delay_flag  = req.in_delay_slot;
         unique case (req.action)
            ACT_RESET: begin
               rsp.new_pc        = VEC_RESET;
               rsp.exc2_code     = EXC2_RESET;
               rsp.status_effect = SE_RESET;
            end
            ACT_NMI: begin
               rsp.new_pc        = VEC_RESET;
               rsp.exc2_code     = EXC2_NMI;
               rsp.status_effect = SE_SET_BEV;
            end
            ACT_PERF: begin
               rsp.new_pc    = req.dev_now ? VEC_PERF_BOOT : VEC_PERF_RAM;
               rsp.exc2_code = EXC2_PERF;
            end
            default: begin
               rsp.new_pc    = req.dev_now ? VEC_DEBUG_BOOT : VEC_DEBUG_RAM;
               rsp.exc2_code = EXC2_DEBUG;
               rsp.set_siop  = (req.action == ACT_SIO);
            end
         endcase
      end
   end

endmodule

// ----- sv/exception_entry_vectoring_core.sv -----
// Exception entry vectoring top level: input register, decode, result register.
// Depends on eev_pkg, eev_req_if, eev_rsp_if and eev_decode.
//
//   port     dir   handshake     payload
//   req_bus  in    valid/ready   eev_pkg::req_type
//   rsp_bus  out   valid/ready   eev_pkg::rsp_type
//
// rsp valid comes from the result register; one item per cycle unless rsp stalls.
// The decode sits between the input register and the result register.
// Synchronous active-high reset clears both stage valid bits.
// A stalled rsp holds the result register; the input register takes a transfer
// while it is empty or while its item moves into the result register.
module exception_entry_vectoring_core (
   input  logic       clock,
   input  logic       reset,
   eev_req_if.sink    req_bus,
   eev_rsp_if.source  rsp_bus
);
   import eev_pkg::*;

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff, in_data_in;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff, out_data_in;
   rsp_type dec_rsp;
   logic    req_xfer;
   logic    out_load;

   eev_decode u_decode (
      .req (in_data_ff),
      .rsp (dec_rsp)
   );

   assign out_load        = in_valid_ff & (~out_valid_ff | rsp_bus.ready);
   assign req_bus.ready   = ~in_valid_ff | out_load;
   assign req_xfer        = req_bus.valid & req_bus.ready;

   assign in_valid_in     = req_xfer | (in_valid_ff & ~out_load);
   assign in_data_in      = req_xfer ? req_bus.payload : in_data_ff;
   assign out_valid_in    = out_load | (out_valid_ff & ~rsp_bus.ready);
   assign out_data_in     = out_load ? dec_rsp : out_data_ff;

   assign rsp_bus.valid   = out_valid_ff;
   assign rsp_bus.payload = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

endmodule
